// File: design/dsld_pkg.sv
// ----------------------------------------------------------------------------
// dsld_pkg
// Shared types and constants for the dual sync length deframer.
// ----------------------------------------------------------------------------
package dsld_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RAW_SYNC_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_SYNC_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MESH_SYNC_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MESH_SYNC_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELIVERY_LIMIT   = 3'd4;

	localparam logic [7:0] DELIVERY_LIMIT_RST = 8'd154;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic [7:0] raw_sync_first;
		logic [7:0] raw_sync_second;
		logic [7:0] mesh_sync_first;
		logic [7:0] mesh_sync_second;
		logic [7:0] delivery_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [7:0]  byte_position;
		logic        is_mesh_frame;
		logic        delivered;
		logic        end_of_frame;
		logic [15:0] source_node;
		logic        overflow_abort;
	} result_t;

	// pair: a sync-word lead result (position 0) goes out before res
	typedef struct packed {
		result_t    res;
		logic       pair;
		logic [7:0] lead_byte;
		logic       lead_delivered;
	} entry_t;

endpackage

// File: design/dsld_front.sv
// ----------------------------------------------------------------------------
// dsld_front
// Sync hunt, frame tracking and result classification for each request.
// ----------------------------------------------------------------------------
module dsld_front #(
	parameter int MAX_PAYLOAD       = 128,
	parameter int RAW_HEADER_BYTES  = 14,
	parameter int MESH_HEADER_BYTES = 12,
	parameter int LENGTH_OFFSET     = 11,
	parameter int NODE_OFFSET       = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsld_pkg::cfg_t  cfg,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output logic            push,
	output dsld_pkg::entry_t entry
);

	localparam int CAPACITY = MAX_PAYLOAD + MESH_HEADER_BYTES + RAW_HEADER_BYTES;
	localparam int NW       = $clog2(MESH_HEADER_BYTES + RAW_HEADER_BYTES + 256);

	localparam logic [NW-1:0] CAP_N      = NW'(CAPACITY);
	localparam logic [NW-1:0] HDR_RAW    = NW'(RAW_HEADER_BYTES);
	localparam logic [NW-1:0] HDR_MESH   = NW'(MESH_HEADER_BYTES + RAW_HEADER_BYTES);
	localparam logic [NW-1:0] LEN_RAW    = NW'(LENGTH_OFFSET);
	localparam logic [NW-1:0] LEN_MESH   = NW'(MESH_HEADER_BYTES + LENGTH_OFFSET);
	localparam logic [NW-1:0] NODE_LO    = NW'(NODE_OFFSET);
	localparam logic [NW-1:0] NODE_HI    = NW'(NODE_OFFSET + 1);
	localparam logic [NW-1:0] POS_ONE    = NW'(1);
	localparam logic [NW-1:0] POS_TWO    = NW'(2);

	logic          in_frame_q, in_frame_n;
	logic [NW-1:0] pos_q, pos_n;
	logic [7:0]    first_q, first_n;
	logic          mesh_q, mesh_n;
	logic [NW-1:0] flen_q, flen_n;
	logic [15:0]   node_q, node_n;

	logic [NW-1:0] limit_n;
	logic [NW-1:0] hdr;
	logic [NW-1:0] len_pos;
	logic [NW-1:0] pos_inc;
	logic          done;
	logic          sync_mesh;
	logic          sync_raw;

	assign limit_n   = NW'(cfg.delivery_limit);
	assign hdr       = mesh_q ? HDR_MESH : HDR_RAW;
	assign len_pos   = mesh_q ? LEN_MESH : LEN_RAW;
	assign pos_inc   = pos_q + POS_ONE;
	assign sync_mesh = (first_q == cfg.mesh_sync_first) && (rx_byte == cfg.mesh_sync_second);
	assign sync_raw  = (first_q == cfg.raw_sync_first) && (rx_byte == cfg.raw_sync_second);

	always_comb begin
		in_frame_n = in_frame_q;
		pos_n      = pos_q;
		first_n    = first_q;
		mesh_n     = mesh_q;
		flen_n     = flen_q;
		node_n     = node_q;
		done       = 1'b0;
		push       = 1'b0;

		entry                    = '0;
		entry.res.frame_byte     = rx_byte;
		entry.res.byte_position  = pos_q[7:0];
		entry.res.is_mesh_frame  = mesh_q;
		entry.lead_byte          = first_q;

		priority if (!in_frame_q) begin
			if (pos_q == '0) begin
				if (rx_byte == cfg.mesh_sync_first || rx_byte == cfg.raw_sync_first) begin
					first_n = rx_byte;
					pos_n   = POS_ONE;
				end
			end else if (sync_mesh || sync_raw) begin
				mesh_n                  = (first_q == cfg.mesh_sync_first);
				in_frame_n              = 1'b1;
				flen_n                  = '0;
				node_n                  = '0;
				pos_n                   = POS_TWO;
				push                    = 1'b1;
				entry.pair              = 1'b1;
				entry.lead_delivered    = (cfg.delivery_limit != 8'd0);
				entry.res.byte_position = 8'd1;
				entry.res.is_mesh_frame = mesh_n;
				entry.res.delivered     = (POS_ONE < limit_n);
			end else begin
				pos_n = '0;
			end
		end else if (pos_q >= CAP_N) begin
			push                     = 1'b1;
			entry.res.overflow_abort = 1'b1;
			in_frame_n               = 1'b0;
			pos_n                    = '0;
			flen_n                   = '0;
		end else begin
			push  = 1'b1;
			pos_n = pos_inc;
			if (mesh_q && pos_q == NODE_LO) begin
				node_n[7:0] = rx_byte;
			end else if (mesh_q && pos_q == NODE_HI) begin
				node_n[15:8] = rx_byte;
			end
			if (pos_q == len_pos && flen_q == '0) begin
				flen_n = hdr + NW'(rx_byte);
			end
			done                   = (flen_n != '0) && (pos_inc >= hdr) && (pos_inc >= flen_n);
			entry.res.delivered    = (pos_q < limit_n);
			entry.res.end_of_frame = done;
			entry.res.source_node  = (done && mesh_q) ? node_n : 16'd0;
			if (done) begin
				in_frame_n = 1'b0;
				pos_n      = '0;
				flen_n     = '0;
			end
		end

		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			first_q    <= '0;
			mesh_q     <= 1'b0;
			flen_q     <= '0;
			node_q     <= '0;
		end else if (accept) begin
			in_frame_q <= in_frame_n;
			pos_q      <= pos_n;
			first_q    <= first_n;
			mesh_q     <= mesh_n;
			flen_q     <= flen_n;
			node_q     <= node_n;
		end
	end

endmodule

// File: design/dsld_queue.sv
// ----------------------------------------------------------------------------
// dsld_queue
// Short entry queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module dsld_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dsld_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output dsld_pkg::entry_t rd_entry
);

	localparam int CW = dsld_pkg::QUEUE_AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(dsld_pkg::QUEUE_DEPTH);

	dsld_pkg::entry_t              mem_q [dsld_pkg::QUEUE_DEPTH];
	logic [dsld_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [dsld_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [CW-1:0]                 count_q;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");
`endif

endmodule

// File: design/dsld_back.sv
// ----------------------------------------------------------------------------
// dsld_back
// Output stage: expands sync pairs into two results and holds the output
// register.
// ----------------------------------------------------------------------------
module dsld_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  dsld_pkg::entry_t q_entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output dsld_pkg::result_t res
);

	logic              out_valid_q;
	dsld_pkg::result_t res_q;
	logic              lead_done_q;
	logic              can_load;
	logic              load_lead;
	dsld_pkg::result_t lead_res;

	assign can_load  = !out_valid_q || out_ready;
	assign load_lead = q_entry.pair && !lead_done_q;
	assign pop       = can_load && q_not_empty && !load_lead;

	always_comb begin
		lead_res               = '0;
		lead_res.frame_byte    = q_entry.lead_byte;
		lead_res.is_mesh_frame = q_entry.res.is_mesh_frame;
		lead_res.delivered     = q_entry.lead_delivered;
	end

	always_ff @(posedge clk) begin
		if (can_load && q_not_empty) begin
			res_q <= load_lead ? lead_res : q_entry.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lead_done_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= q_not_empty;
			if (q_not_empty) begin
				lead_done_q <= load_lead;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_lead_then_pop: assert property (@(posedge clk) disable iff (!arst_n)
		lead_done_q |-> (q_not_empty && q_entry.pair))
		else $error("lead sent without its pair pending");

	a_lead_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lead_done_q) |-> (out_valid_q && res_q.byte_position == 8'd0
			&& !res_q.end_of_frame && !res_q.overflow_abort))
		else $error("sync lead result malformed");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(res_q)))
		else $error("output changed while stalled");
`endif

endmodule

// File: design/dual_sync_length_deframer_core.sv
// ----------------------------------------------------------------------------
// dual_sync_length_deframer_core
// Hunts for a raw or mesh two-byte sync word and streams frame bytes out
// with index, delivery flag, end mark, mesh source node and overflow abort.
//
// Takes one byte per cycle while the queue has room. Hunting bytes give no
// result; each in-frame byte gives one; the byte that completes a sync word
// gives two, lead first. Each result is written into the queue when its byte
// is accepted and then loaded into the output register. A four-entry queue
// sits between the classifier and the output register, so input is accepted
// whenever the queue has room and the output side stalls independently.
// Sustained output is one result per cycle while out_ready is high; the extra
// result of a sync pair is offset by the lead sync byte, which has no result,
// so input is throttled only when the queue fills behind a slow consumer.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// by the user, who must do so only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_sync_length_deframer_core #(
	parameter int MAX_PAYLOAD       = 128,
	parameter int RAW_HEADER_BYTES  = 14,
	parameter int MESH_HEADER_BYTES = 12,
	parameter int LENGTH_OFFSET     = 11,
	parameter int NODE_OFFSET       = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [dsld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       frame_byte,
	output logic [7:0]                       byte_position,
	output logic                             is_mesh_frame,
	output logic                             delivered,
	output logic                             end_of_frame,
	output logic [15:0]                      source_node,
	output logic                             overflow_abort
);

	dsld_pkg::cfg_t    cfg_q;
	dsld_pkg::entry_t  wr_entry;
	dsld_pkg::entry_t  rd_entry;
	dsld_pkg::result_t res;
	logic              accept;
	logic              push;
	logic              full;
	logic              pop;
	logic              not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_sync_first   <= '0;
			cfg_q.raw_sync_second  <= '0;
			cfg_q.mesh_sync_first  <= '0;
			cfg_q.mesh_sync_second <= '0;
			cfg_q.delivery_limit   <= dsld_pkg::DELIVERY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dsld_pkg::REG_RAW_SYNC_FIRST:   cfg_q.raw_sync_first   <= cfg_data;
				dsld_pkg::REG_RAW_SYNC_SECOND:  cfg_q.raw_sync_second  <= cfg_data;
				dsld_pkg::REG_MESH_SYNC_FIRST:  cfg_q.mesh_sync_first  <= cfg_data;
				dsld_pkg::REG_MESH_SYNC_SECOND: cfg_q.mesh_sync_second <= cfg_data;
				dsld_pkg::REG_DELIVERY_LIMIT:   cfg_q.delivery_limit   <= cfg_data;
				default:                        cfg_q                  <= cfg_q;
			endcase
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	dsld_front #(
		.MAX_PAYLOAD       (MAX_PAYLOAD),
		.RAW_HEADER_BYTES  (RAW_HEADER_BYTES),
		.MESH_HEADER_BYTES (MESH_HEADER_BYTES),
		.LENGTH_OFFSET     (LENGTH_OFFSET),
		.NODE_OFFSET       (NODE_OFFSET)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.rx_byte (rx_byte),
		.push    (push),
		.entry   (wr_entry)
	);

	dsld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_entry  (rd_entry)
	);

	dsld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_entry     (rd_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign frame_byte     = res.frame_byte;
	assign byte_position  = res.byte_position;
	assign is_mesh_frame  = res.is_mesh_frame;
	assign delivered      = res.delivered;
	assign end_of_frame   = res.end_of_frame;
	assign source_node    = res.source_node;
	assign overflow_abort = res.overflow_abort;

endmodule

// File: bench/dual_sync_length_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// dual_sync_length_deframer_core_tb
// Self-checking bench for the dual sync length deframer. Streams received
// bytes (noise, broken sync words, raw and mesh frames of random content,
// exact-fit and overflowing frames) through a series of sync word and
// delivery limit settings. A scoreboard tracks hunt and frame state for
// every accepted byte and checks each output result in order. Both
// handshakes see random gaps.
// ----------------------------------------------------------------------------
module dual_sync_length_deframer_core_tb;

	localparam int MAX_PAYLOAD       = 128;
	localparam int RAW_HEADER_BYTES  = 14;
	localparam int MESH_HEADER_BYTES = 12;
	localparam int LENGTH_OFFSET     = 11;
	localparam int NODE_OFFSET       = 4;
	localparam int CAPACITY          = MAX_PAYLOAD + MESH_HEADER_BYTES + RAW_HEADER_BYTES;
	localparam int HALF_PERIOD       = 10;
	localparam int FRAME_ITEMS       = 1750;
	localparam int CYCLE_LIMIT       = 1000000;

	class frame_checker;
		dsld_pkg::cfg_t    regs;
		bit                framing;
		int unsigned       count;
		logic [7:0]        lead;
		bit                mesh;
		int unsigned       flen;
		logic [15:0]       node;
		dsld_pkg::result_t pending_results[$];
		int                mismatches;

		function new();
			regs = '0;
			regs.delivery_limit = dsld_pkg::DELIVERY_LIMIT_RST;
			framing = 1'b0;
			count = 0;
			lead = '0;
			mesh = 1'b0;
			flen = 0;
			node = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [dsld_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
			case (idx)
				dsld_pkg::REG_RAW_SYNC_FIRST:   regs.raw_sync_first = v;
				dsld_pkg::REG_RAW_SYNC_SECOND:  regs.raw_sync_second = v;
				dsld_pkg::REG_MESH_SYNC_FIRST:  regs.mesh_sync_first = v;
				dsld_pkg::REG_MESH_SYNC_SECOND: regs.mesh_sync_second = v;
				dsld_pkg::REG_DELIVERY_LIMIT:   regs.delivery_limit = v;
				default: ;
			endcase
		endfunction

		function void push(logic [7:0] b, int unsigned p, bit eof, logic [15:0] nd, bit abort);
			dsld_pkg::result_t r;
			r.frame_byte     = b;
			r.byte_position  = p[7:0];
			r.is_mesh_frame  = mesh;
			r.delivered      = !abort && (p < regs.delivery_limit);
			r.end_of_frame   = eof;
			r.source_node    = nd;
			r.overflow_abort = abort;
			pending_results.push_back(r);
		endfunction

		function void note_rx_byte(logic [7:0] b);
			int unsigned hdr;
			int unsigned len_at;
			int unsigned p;
			bit done;
			if (!framing) begin
				if (count == 0) begin
					if (b == regs.mesh_sync_first || b == regs.raw_sync_first) begin
						lead = b;
						count = 1;
					end
					return;
				end
				if ((lead == regs.mesh_sync_first && b == regs.mesh_sync_second) ||
						(lead == regs.raw_sync_first && b == regs.raw_sync_second)) begin
					mesh = (lead == regs.mesh_sync_first);
					framing = 1'b1;
					flen = 0;
					node = '0;
					push(lead, 0, 1'b0, 16'h0, 1'b0);
					push(b, 1, 1'b0, 16'h0, 1'b0);
					count = 2;
				end else begin
					// bad second byte is dropped, not retried as a lead
					count = 0;
				end
				return;
			end
			if (count >= CAPACITY) begin
				push(b, count, 1'b0, 16'h0, 1'b1);
				framing = 1'b0;
				count = 0;
				flen = 0;
				return;
			end
			hdr = mesh ? MESH_HEADER_BYTES + RAW_HEADER_BYTES : RAW_HEADER_BYTES;
			len_at = mesh ? MESH_HEADER_BYTES + LENGTH_OFFSET : LENGTH_OFFSET;
			p = count;
			count = p + 1;
			if (mesh && p == NODE_OFFSET)
				node[7:0] = b;
			else if (mesh && p == NODE_OFFSET + 1)
				node[15:8] = b;
			if (p == len_at && flen == 0)
				flen = hdr + b;
			done = (flen != 0) && (count >= hdr) && (count >= flen);
			push(b, p, done, (done && mesh) ? node : 16'h0, 1'b0);
			if (done) begin
				framing = 1'b0;
				count = 0;
				flen = 0;
			end
		endfunction

		function string show(dsld_pkg::result_t r);
			return $sformatf("byte %h pos %0d mesh %b dlv %b eof %b node %h abort %b",
				r.frame_byte, r.byte_position, r.is_mesh_frame, r.delivered,
				r.end_of_frame, r.source_node, r.overflow_abort);
		endfunction

		function void check_frame_result(dsld_pkg::result_t got);
			dsld_pkg::result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = pending_results.pop_front();
			if (got.frame_byte !== want.frame_byte || got.byte_position !== want.byte_position ||
					got.is_mesh_frame !== want.is_mesh_frame ||
					got.delivered !== want.delivered || got.end_of_frame !== want.end_of_frame ||
					got.source_node !== want.source_node ||
					got.overflow_abort !== want.overflow_abort) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch at %0t: expected %s, got %s",
						$realtime, show(want), show(got));
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [dsld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [7:0]                     rx_byte = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [7:0]                     frame_byte;
	logic [7:0]                     byte_position;
	logic                           is_mesh_frame;
	logic                           delivered;
	logic                           end_of_frame;
	logic [15:0]                    source_node;
	logic                           overflow_abort;

	frame_checker sb = new();
	bit           calm = 1'b0;
	int unsigned  frame_items = 0;
	int unsigned  cycles = 0;
	int unsigned  ready_hold = 0;

	dual_sync_length_deframer_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.RAW_HEADER_BYTES(RAW_HEADER_BYTES),
		.MESH_HEADER_BYTES(MESH_HEADER_BYTES),
		.LENGTH_OFFSET(LENGTH_OFFSET),
		.NODE_OFFSET(NODE_OFFSET)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_byte(frame_byte),
		.byte_position(byte_position),
		.is_mesh_frame(is_mesh_frame),
		.delivered(delivered),
		.end_of_frame(end_of_frame),
		.source_node(source_node),
		.overflow_abort(overflow_abort)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_rx_byte(rx_byte);
		if (arst_n && out_valid && out_ready)
			sb.check_frame_result({frame_byte, byte_position, is_mesh_frame, delivered,
				end_of_frame, source_node, overflow_abort});
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	always @(negedge clk) begin
		if (ready_hold != 0) begin
			out_ready = 1'b0;
			ready_hold--;
		end else begin
			out_ready = 1'b1;
			ready_hold = pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [dsld_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic apply_config(input dsld_pkg::cfg_t c);
		write_reg(dsld_pkg::REG_RAW_SYNC_FIRST, c.raw_sync_first);
		write_reg(dsld_pkg::REG_RAW_SYNC_SECOND, c.raw_sync_second);
		write_reg(dsld_pkg::REG_MESH_SYNC_FIRST, c.mesh_sync_first);
		write_reg(dsld_pkg::REG_MESH_SYNC_SECOND, c.mesh_sync_second);
		write_reg(dsld_pkg::REG_DELIVERY_LIMIT, c.delivery_limit);
	endtask

	// block is idle once every request has come back and the queue is flushed
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// as_mesh picks the sync pair; layout follows what the block will decode
	task automatic send_frame(input bit as_mesh, input logic [7:0] len);
		bit          mesh_layout;
		int unsigned hdr;
		int unsigned len_at;
		int unsigned total;
		logic [7:0]  b;
		mesh_layout = as_mesh || (sb.regs.raw_sync_first == sb.regs.mesh_sync_first);
		hdr = mesh_layout ? MESH_HEADER_BYTES + RAW_HEADER_BYTES : RAW_HEADER_BYTES;
		len_at = mesh_layout ? MESH_HEADER_BYTES + LENGTH_OFFSET : LENGTH_OFFSET;
		total = hdr + len;
		if (total > CAPACITY + 1)
			total = CAPACITY + 1;
		for (int i = 0; i < total; i++) begin
			if (i == 0)
				b = as_mesh ? sb.regs.mesh_sync_first : sb.regs.raw_sync_first;
			else if (i == 1)
				b = as_mesh ? sb.regs.mesh_sync_second : sb.regs.raw_sync_second;
			else if (i == len_at)
				b = len;
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b);
		end
		frame_items += total;
	endtask

	task automatic send_noise(input int unsigned n);
		logic [7:0] b;
		repeat (n) begin
			do begin
				b = 8'($urandom_range(0, 255));
			end while (b == sb.regs.raw_sync_first || b == sb.regs.mesh_sync_first);
			send_byte(b);
		end
	endtask

	task automatic send_broken_sync();
		logic [7:0] first;
		logic [7:0] bad;
		first = $urandom_range(0, 1) ? sb.regs.mesh_sync_first : sb.regs.raw_sync_first;
		do begin
			bad = 8'($urandom_range(0, 255));
		end while (bad == sb.regs.raw_sync_second || bad == sb.regs.mesh_sync_second);
		send_byte(first);
		send_byte(bad);
	endtask

	function automatic dsld_pkg::cfg_t pick_config(input int unsigned k);
		dsld_pkg::cfg_t c;
		c.raw_sync_first   = 8'($urandom_range(0, 255));
		c.raw_sync_second  = 8'($urandom_range(0, 255));
		c.mesh_sync_first  = 8'($urandom_range(0, 255));
		c.mesh_sync_second = 8'($urandom_range(0, 255));
		c.delivery_limit   = 8'($urandom_range(0, CAPACITY));
		case (k % 6)
			0: begin
				c.raw_sync_first = 8'h00;
				c.raw_sync_second = 8'hff;
				c.mesh_sync_first = 8'hff;
				c.mesh_sync_second = 8'h00;
				c.delivery_limit = 8'd0;
			end
			1: begin
				c.delivery_limit = 8'(CAPACITY);
			end
			2: begin
				c.mesh_sync_first = c.raw_sync_first;
			end
			3: begin
				c.raw_sync_second = c.raw_sync_first;
				c.mesh_sync_first = c.raw_sync_first;
				c.mesh_sync_second = c.raw_sync_first;
				c.delivery_limit = 8'd1;
			end
			4: begin
				c.raw_sync_first = 8'hff;
				c.raw_sync_second = 8'hff;
				c.mesh_sync_first = 8'h00;
				c.mesh_sync_second = 8'h00;
				c.delivery_limit = 8'(CAPACITY);
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick_length(input bit as_mesh);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return as_mesh ? 8'(CAPACITY - MESH_HEADER_BYTES - RAW_HEADER_BYTES)
				: 8'(CAPACITY - RAW_HEADER_BYTES);
		if (r < 6)
			return 8'($urandom_range(129, 255));
		if (r < 14)
			return 8'd0;
		if (r < 17)
			return 8'($urandom_range(25, 100));
		return 8'($urandom_range(1, 24));
	endfunction

	initial begin
		dsld_pkg::cfg_t c;
		int unsigned    phase;
		bit             as_mesh;
		int unsigned    r;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: both leads are zero, so frames decode as mesh
		send_frame(1'b1, 8'd3);
		send_frame(1'b0, 8'd0);
		settle();

		c.raw_sync_first   = 8'ha5;
		c.raw_sync_second  = 8'h5a;
		c.mesh_sync_first  = 8'h7e;
		c.mesh_sync_second = 8'h81;
		c.delivery_limit   = 8'd20;
		apply_config(c);
		send_byte(8'h00);
		send_byte(8'hff);
		// bad second byte equal to the other lead is not taken as a new lead
		send_byte(8'ha5);
		send_byte(8'h7e);
		send_byte(8'h81);
		// lead of one pair followed by the second of the other
		send_byte(8'h7e);
		send_byte(8'h5a);
		send_frame(1'b0, 8'd0);
		settle();

		phase = 0;
		while (frame_items < FRAME_ITEMS) begin
			apply_config(pick_config(phase));
			phase++;
			repeat ($urandom_range(4, 8)) begin
				calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 10)
					send_noise($urandom_range(1, 4));
				else if (r < 18)
					send_broken_sync();
				as_mesh = 1'($urandom_range(0, 1));
				send_frame(as_mesh, pick_length(as_mesh));
			end
			calm = 1'b0;
			settle();
		end

		settle();
		sb.mismatches += sb.pending_results.size();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
design/dsld_pkg.sv
design/dsld_front.sv
design/dsld_queue.sv
design/dsld_back.sv
design/dual_sync_length_deframer_core.sv
bench/dual_sync_length_deframer_core_tb.sv
